@@ hw/rtl/cfd_pkg.sv @@
package cfd_pkg;

    localparam int PARAM_MAX   = 16;
    localparam int HDR_BYTES   = 4;
    localparam int TRAIL_BYTES = 4;
    localparam int STORE_DEPTH = PARAM_MAX + HDR_BYTES + TRAIL_BYTES;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int EIDX_W      = $clog2(PARAM_MAX + 1);
    localparam int BYTE_W      = 8;
    localparam int SUM_W       = BYTE_W + 1;
    localparam int COUNT_W     = 5;
    localparam int PIDX_W      = 4;
    localparam int CFG_IDX_W   = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_FIRST  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SECOND = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_FILL    = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_FOOTER_FIRST  = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_FOOTER_SECOND = CFG_IDX_W'(4);

    typedef enum logic [2:0] {
        ENG_IDLE,
        ENG_PARSE,
        ENG_FETCH,
        ENG_EMIT,
        ENG_COPY
    } t_eng_state;

    typedef enum logic [3:0] {
        PH_HUNT0,
        PH_HUNT1,
        PH_SRC,
        PH_DST,
        PH_CMD,
        PH_LEN,
        PH_PARAM,
        PH_CHK0,
        PH_CHK1,
        PH_FT0,
        PH_FT1
    } t_phase;

    typedef struct packed {
        logic take_in;
        logic fetch;
        logic store_wr;
        logic count_clr;
        logic cap_src;
        logic cap_dst;
        logic cap_cmd;
        logic cap_len;
        logic emit_load;
        logic emit_addr;
        logic copy_step;
        logic copy_done;
        logic replay_end;
    } t_dp_cmd;

    typedef struct packed {
        logic hf_hit;
        logic hs_hit;
        logic fill_hit;
        logic ft0_hit;
        logic ft1_hit;
        logic len_big;
        logic len_zero;
        logic params_done;
        logic src_more;
        logic emit_last;
        logic out_free;
    } t_dp_status;

endpackage

@@ hw/rtl/cfd_ifs.sv @@
interface cfd_byte_if;
    import cfd_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface cfd_result_if;
    import cfd_pkg::*;
    logic               valid;
    logic               ready;
    logic [BYTE_W-1:0]  src_device;
    logic [BYTE_W-1:0]  dst_device;
    logic [BYTE_W-1:0]  command;
    logic [COUNT_W-1:0] param_count;
    logic               has_param;
    logic [PIDX_W-1:0]  param_index;
    logic [BYTE_W-1:0]  param_byte;
    logic               last;
    modport source (
        output valid, output src_device, output dst_device, output command,
        output param_count, output has_param, output param_index,
        output param_byte, output last, input ready
    );
    modport sink (
        input valid, input src_device, input dst_device, input command,
        input param_count, input has_param, input param_index,
        input param_byte, input last, output ready
    );
endinterface

interface cfd_cfg_if;
    import cfd_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [BYTE_W-1:0]    data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/cfd_ctrl.sv @@
module cfd_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  cfd_pkg::t_dp_status i_status,
    output cfd_pkg::t_dp_cmd    o_cmd
);
    import cfd_pkg::*;

    t_eng_state r_state;
    t_eng_state n_state;
    t_phase     r_phase;
    t_phase     n_phase;
    logic       r_check_ok;
    logic       n_check_ok;
    logic       r_in_replay;
    logic       n_in_replay;
    logic       w_frame_end;
    logic       w_frame_good;

    assign w_frame_end  = (r_phase == PH_FT1);
    assign w_frame_good = r_check_ok && i_status.ft1_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ENG_IDLE;
            r_phase     <= PH_HUNT0;
            r_check_ok  <= 1'b1;
            r_in_replay <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_check_ok  <= n_check_ok;
            r_in_replay <= n_in_replay;
        end
    end

    // next state: engine sequencing and frame phase
    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_check_ok  = r_check_ok;
        n_in_replay = r_in_replay;
        case (r_state)
            ENG_IDLE: begin
                if (i_in_valid) begin
                    n_state = ENG_PARSE;
                end
            end
            ENG_PARSE: begin
                case (r_phase)
                    PH_HUNT1: begin
                        if (i_status.hs_hit) begin
                            n_check_ok = 1'b1;
                            n_phase    = PH_SRC;
                        end else begin
                            n_phase = i_status.hf_hit ? PH_HUNT1 : PH_HUNT0;
                        end
                    end
                    PH_SRC: n_phase = PH_DST;
                    PH_DST: n_phase = PH_CMD;
                    PH_CMD: n_phase = PH_LEN;
                    PH_LEN: begin
                        if (i_status.len_big) begin
                            n_phase = PH_HUNT0;
                        end else if (i_status.len_zero) begin
                            n_phase = PH_CHK0;
                        end else begin
                            n_phase = PH_PARAM;
                        end
                    end
                    PH_PARAM: begin
                        if (i_status.params_done) begin
                            n_phase = PH_CHK0;
                        end
                    end
                    PH_CHK0: begin
                        if (!i_status.fill_hit) begin
                            n_check_ok = 1'b0;
                        end
                        n_phase = PH_CHK1;
                    end
                    PH_CHK1: begin
                        if (!i_status.fill_hit) begin
                            n_check_ok = 1'b0;
                        end
                        n_phase = PH_FT0;
                    end
                    PH_FT0: begin
                        if (!i_status.ft0_hit) begin
                            n_check_ok = 1'b0;
                        end
                        n_phase = PH_FT1;
                    end
                    PH_FT1: begin
                        n_phase    = PH_HUNT0;
                        n_check_ok = 1'b1;
                    end
                    default: begin
                        n_phase = i_status.hf_hit ? PH_HUNT1 : PH_HUNT0;
                    end
                endcase
                if (w_frame_end && w_frame_good) begin
                    n_state = ENG_EMIT;
                end else if (w_frame_end) begin
                    n_state     = ENG_COPY;
                    n_in_replay = 1'b1;
                end else if (r_in_replay) begin
                    n_state = ENG_FETCH;
                end else begin
                    n_state = ENG_IDLE;
                end
            end
            ENG_FETCH: begin
                if (i_status.src_more) begin
                    n_state = ENG_PARSE;
                end else begin
                    n_state     = ENG_IDLE;
                    n_in_replay = 1'b0;
                end
            end
            ENG_EMIT: begin
                if (i_status.out_free && i_status.emit_last) begin
                    n_state = r_in_replay ? ENG_FETCH : ENG_IDLE;
                end
            end
            ENG_COPY: begin
                if (!i_status.src_more) begin
                    n_state = ENG_FETCH;
                end
            end
            default: n_state = ENG_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ENG_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.take_in = i_in_valid;
            end
            ENG_PARSE: begin
                case (r_phase)
                    PH_HUNT1: o_cmd.count_clr = i_status.hs_hit;
                    PH_SRC: begin
                        o_cmd.store_wr = 1'b1;
                        o_cmd.cap_src  = 1'b1;
                    end
                    PH_DST: begin
                        o_cmd.store_wr = 1'b1;
                        o_cmd.cap_dst  = 1'b1;
                    end
                    PH_CMD: begin
                        o_cmd.store_wr = 1'b1;
                        o_cmd.cap_cmd  = 1'b1;
                    end
                    PH_LEN: begin
                        o_cmd.store_wr  = 1'b1;
                        o_cmd.cap_len   = 1'b1;
                        o_cmd.count_clr = i_status.len_big;
                    end
                    PH_PARAM, PH_CHK0, PH_CHK1, PH_FT0: o_cmd.store_wr = 1'b1;
                    PH_FT1: begin
                        o_cmd.store_wr  = 1'b1;
                        o_cmd.count_clr = w_frame_good;
                        o_cmd.emit_addr = w_frame_good;
                    end
                    default: o_cmd.store_wr = 1'b0;
                endcase
            end
            ENG_FETCH: begin
                o_cmd.fetch      = i_status.src_more;
                o_cmd.replay_end = !i_status.src_more;
            end
            ENG_EMIT: begin
                o_cmd.emit_load = i_status.out_free;
                o_cmd.emit_addr = !(i_status.out_free && i_status.emit_last);
            end
            ENG_COPY: begin
                o_cmd.copy_step = i_status.src_more;
                o_cmd.copy_done = !i_status.src_more;
            end
            default: o_in_ready = 1'b0;
        endcase
    end

endmodule

@@ hw/rtl/cfd_dpath.sv @@
module cfd_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [cfd_pkg::BYTE_W-1:0]    i_rx_byte,
    cfd_cfg_if.sink                       i_cfg,
    cfd_result_if.source                  o_res,
    input  cfd_pkg::t_dp_cmd              i_cmd,
    output cfd_pkg::t_dp_status           o_status
);
    import cfd_pkg::*;

    logic [BYTE_W-1:0]  r_header_first;
    logic [BYTE_W-1:0]  r_header_second;
    logic [BYTE_W-1:0]  r_check_fill;
    logic [BYTE_W-1:0]  r_footer_first;
    logic [BYTE_W-1:0]  r_footer_second;

    logic [BYTE_W-1:0]  r_store [STORE_DEPTH];
    logic [BYTE_W-1:0]  r_rd_data;
    logic [BYTE_W-1:0]  r_byte;
    logic [BYTE_W-1:0]  r_src;
    logic [BYTE_W-1:0]  r_dst;
    logic [BYTE_W-1:0]  r_cmd;
    logic [BYTE_W-1:0]  r_len;

    logic [CNT_W-1:0]   r_byte_count;
    logic [CNT_W-1:0]   n_byte_count;
    logic [CNT_W-1:0]   r_replay_ptr;
    logic [CNT_W-1:0]   n_replay_ptr;
    logic [CNT_W-1:0]   r_replay_len;
    logic [CNT_W-1:0]   n_replay_len;
    logic [EIDX_W-1:0]  r_emit_idx;
    logic [EIDX_W-1:0]  n_emit_idx;

    logic               r_out_valid;
    logic [BYTE_W-1:0]  r_out_src;
    logic [BYTE_W-1:0]  r_out_dst;
    logic [BYTE_W-1:0]  r_out_cmd;
    logic [COUNT_W-1:0] r_out_count;
    logic               r_out_has;
    logic [PIDX_W-1:0]  r_out_index;
    logic [BYTE_W-1:0]  r_out_param;
    logic               r_out_last;

    logic [ADDR_W-1:0]  w_rd_addr;
    logic               w_room;
    logic               w_wr_en;
    logic [BYTE_W-1:0]  w_wr_data;
    logic               w_len_zero;
    logic               w_emit_last;

    // configuration
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_first  <= '0;
            r_header_second <= '0;
            r_check_fill    <= '0;
            r_footer_first  <= '0;
            r_footer_second <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_HEADER_FIRST:  r_header_first  <= i_cfg.data;
                CFG_HEADER_SECOND: r_header_second <= i_cfg.data;
                CFG_CHECK_FILL:    r_check_fill    <= i_cfg.data;
                CFG_FOOTER_FIRST:  r_footer_first  <= i_cfg.data;
                CFG_FOOTER_SECOND: r_footer_second <= i_cfg.data;
                default:           r_header_first  <= r_header_first;
            endcase
        end
    end

    // frame store, one read and one write port
    assign w_rd_addr = i_cmd.emit_addr
                     ? ADDR_W'(HDR_BYTES) + ADDR_W'(n_emit_idx)
                     : n_replay_ptr[ADDR_W-1:0];
    assign w_room    = (r_byte_count < CNT_W'(STORE_DEPTH));
    assign w_wr_en   = (i_cmd.store_wr && w_room) || i_cmd.copy_step;
    assign w_wr_data = i_cmd.copy_step ? r_rd_data : r_byte;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_store[r_byte_count[ADDR_W-1:0]] <= w_wr_data;
        end
        r_rd_data <= r_store[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in) begin
            r_byte <= i_rx_byte;
        end else if (i_cmd.fetch) begin
            r_byte <= r_rd_data;
        end
        if (i_cmd.cap_src) begin
            r_src <= r_byte;
        end
        if (i_cmd.cap_dst) begin
            r_dst <= r_byte;
        end
        if (i_cmd.cap_cmd) begin
            r_cmd <= r_byte;
        end
        if (i_cmd.cap_len) begin
            r_len <= r_byte;
        end
    end

    // counters
    assign w_len_zero  = (r_len == '0);
    assign w_emit_last = w_len_zero
                       || (SUM_W'(r_emit_idx) + SUM_W'(1) == SUM_W'(r_len));

    always_comb begin
        n_byte_count = r_byte_count;
        n_replay_ptr = r_replay_ptr;
        n_replay_len = r_replay_len;
        n_emit_idx   = r_emit_idx;
        if (i_cmd.count_clr || i_cmd.copy_done) begin
            n_byte_count = '0;
        end else if ((i_cmd.store_wr && w_room) || i_cmd.copy_step) begin
            n_byte_count = r_byte_count + CNT_W'(1);
        end
        if (i_cmd.fetch || i_cmd.copy_step) begin
            n_replay_ptr = r_replay_ptr + CNT_W'(1);
        end else if (i_cmd.copy_done || i_cmd.replay_end) begin
            n_replay_ptr = '0;
        end
        if (i_cmd.copy_done) begin
            n_replay_len = r_byte_count;
        end else if (i_cmd.replay_end) begin
            n_replay_len = '0;
        end
        if (i_cmd.emit_load) begin
            n_emit_idx = w_emit_last ? '0 : r_emit_idx + EIDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
            r_replay_ptr <= '0;
            r_replay_len <= '0;
            r_emit_idx   <= '0;
        end else begin
            r_byte_count <= n_byte_count;
            r_replay_ptr <= n_replay_ptr;
            r_replay_len <= n_replay_len;
            r_emit_idx   <= n_emit_idx;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_load) begin
            r_out_src   <= r_src;
            r_out_dst   <= r_dst;
            r_out_cmd   <= r_cmd;
            r_out_count <= r_len[COUNT_W-1:0];
            r_out_has   <= !w_len_zero;
            r_out_index <= r_emit_idx[PIDX_W-1:0];
            r_out_param <= w_len_zero ? '0 : r_rd_data;
            r_out_last  <= w_emit_last;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.src_device  = r_out_src;
    assign o_res.dst_device  = r_out_dst;
    assign o_res.command     = r_out_cmd;
    assign o_res.param_count = r_out_count;
    assign o_res.has_param   = r_out_has;
    assign o_res.param_index = r_out_index;
    assign o_res.param_byte  = r_out_param;
    assign o_res.last        = r_out_last;

    // status back to the controller
    assign o_status.hf_hit      = (r_byte == r_header_first);
    assign o_status.hs_hit      = (r_byte == r_header_second);
    assign o_status.fill_hit    = (r_byte == r_check_fill);
    assign o_status.ft0_hit     = (r_byte == r_footer_first);
    assign o_status.ft1_hit     = (r_byte == r_footer_second);
    assign o_status.len_big     = (r_byte > BYTE_W'(PARAM_MAX));
    assign o_status.len_zero    = (r_byte == '0);
    assign o_status.params_done = (SUM_W'(r_byte_count) + SUM_W'(1))
                                  >= (SUM_W'(HDR_BYTES) + SUM_W'(r_len));
    assign o_status.src_more    = (r_replay_ptr < r_replay_len);
    assign o_status.emit_last   = w_emit_last;
    assign o_status.out_free    = !r_out_valid || o_res.ready;

endmodule

@@ hw/rtl/command_frame_deframer.sv @@
// Command frame deframer. Received link bytes enter one beat at a time; the
// block hunts for the two-byte header, collects source, target, command and
// length, then the parameter bytes, two check bytes that must equal the fill
// value and the two-byte footer. A good frame gives one result beat per
// parameter byte (one beat for an empty frame), with last set on the final
// beat. A length above the limit drops the header. A bad check or footer
// byte makes the block reparse the bytes after that header from its 24-byte
// frame store. Each input byte is captured, then parsed. A good frame then
// emits its result beats, held while the result side stalls. A bad frame
// replays its stored bytes, each fetched and then parsed; a bad frame found
// inside the replay first moves the stored bytes behind it down the store.
// No input beat is taken meanwhile.
// Configuration writes (header, fill and footer bytes) are taken at any time
// and should only be made while the block is idle.
module command_frame_deframer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cfd_byte_if.sink      i_rx,
    cfd_result_if.source  o_res,
    cfd_cfg_if.sink       i_cfg
);
    import cfd_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    cfd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_rx.valid),
        .o_in_ready (i_rx.ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    cfd_dpath u_dpath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rx_byte (i_rx.rx_byte),
        .i_cfg     (i_cfg),
        .o_res     (o_res),
        .i_cmd     (w_cmd),
        .o_status  (w_status)
    );

endmodule

@@ sim/command_frame_deframer_checker.sv @@
`timescale 1ns / 1ps
module command_frame_deframer_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    cfd_byte_if   i_rx,
    cfd_result_if i_res,
    cfd_cfg_if    i_cfg,
    output int    o_fail_count,
    output int    o_pending,
    output int    o_beats,
    output int    o_reparsed
);
    import cfd_pkg::*;

    localparam int MAX_BEATS = 32;

    typedef struct packed {
        logic [BYTE_W-1:0]  src;
        logic [BYTE_W-1:0]  dst;
        logic [BYTE_W-1:0]  cmd;
        logic [COUNT_W-1:0] count;
        logic               has_param;
        logic [PIDX_W-1:0]  pidx;
        logic [BYTE_W-1:0]  pbyte;
        logic               last;
    } cmd_result_t;

    cmd_result_t       owed_beats [$];
    t_phase            parse_at;
    logic [BYTE_W-1:0] store [STORE_DEPTH];
    int unsigned       store_fill;
    bit                frame_ok;
    int                step_beats;
    logic [BYTE_W-1:0] reg_hf, reg_hs, reg_fill, reg_f0, reg_f1;
    int                fail_count = 0;
    int                beat_count = 0;
    int                reparse_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = owed_beats.size();
    assign o_beats      = beat_count;
    assign o_reparsed   = reparse_count;

    function automatic void keep_byte(logic [BYTE_W-1:0] b);
        if (store_fill < STORE_DEPTH) begin
            store[store_fill] = b;
            store_fill++;
        end
    endfunction

    // one byte through the frame parser, returns 1 when a frame is rejected
    function automatic bit parse_byte(logic [BYTE_W-1:0] b);
        bit          rejected = 1'b0;
        int unsigned len;
        int unsigned total;
        cmd_result_t r;
        case (parse_at)
            PH_HUNT1: begin
                if (b == reg_hs) begin
                    store_fill = 0;
                    frame_ok   = 1'b1;
                    parse_at   = PH_SRC;
                end else begin
                    parse_at = (b == reg_hf) ? PH_HUNT1 : PH_HUNT0;
                end
            end
            PH_SRC: begin
                keep_byte(b);
                parse_at = PH_DST;
            end
            PH_DST: begin
                keep_byte(b);
                parse_at = PH_CMD;
            end
            PH_CMD: begin
                keep_byte(b);
                parse_at = PH_LEN;
            end
            PH_LEN: begin
                keep_byte(b);
                if (b > PARAM_MAX) begin
                    store_fill = 0;
                    parse_at   = PH_HUNT0;
                end else begin
                    parse_at = (b == 0) ? PH_CHK0 : PH_PARAM;
                end
            end
            PH_PARAM: begin
                keep_byte(b);
                if (store_fill >= 4 + store[3]) parse_at = PH_CHK0;
            end
            PH_CHK0: begin
                keep_byte(b);
                if (b != reg_fill) frame_ok = 1'b0;
                parse_at = PH_CHK1;
            end
            PH_CHK1: begin
                keep_byte(b);
                if (b != reg_fill) frame_ok = 1'b0;
                parse_at = PH_FT0;
            end
            PH_FT0: begin
                keep_byte(b);
                if (b != reg_f0) frame_ok = 1'b0;
                parse_at = PH_FT1;
            end
            PH_FT1: begin
                keep_byte(b);
                if (b != reg_f1) frame_ok = 1'b0;
                parse_at = PH_HUNT0;
                if (frame_ok) begin
                    len   = store[3];
                    total = (len == 0) ? 1 : len;
                    for (int i = 0; i < total; i++) begin
                        if (step_beats < MAX_BEATS) begin
                            r.src       = store[0];
                            r.dst       = store[1];
                            r.cmd       = store[2];
                            r.count     = len[COUNT_W-1:0];
                            r.has_param = (len != 0);
                            r.pidx      = (len != 0) ? i[PIDX_W-1:0] : '0;
                            r.pbyte     = (len != 0 && 4 + i < STORE_DEPTH) ? store[4 + i] : '0;
                            r.last      = (i + 1 == total);
                            owed_beats.push_back(r);
                            step_beats++;
                        end
                    end
                    store_fill = 0;
                end else begin
                    frame_ok = 1'b1;
                    rejected = 1'b1;
                end
            end
            default: parse_at = (b == reg_hf) ? PH_HUNT1 : PH_HUNT0;
        endcase
        return rejected;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        cmd_result_t       got;
        cmd_result_t       want;
        int unsigned       run_len;
        int unsigned       pos;
        int unsigned       inner;
        int unsigned       rest;
        logic [BYTE_W-1:0] nb;
        if (!i_rst_n) begin
            parse_at   = PH_HUNT0;
            store_fill = 0;
            frame_ok   = 1'b1;
            reg_hf     = '0;
            reg_hs     = '0;
            reg_fill   = '0;
            reg_f0     = '0;
            reg_f1     = '0;
            foreach (store[i]) store[i] = '0;
            owed_beats.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_HEADER_FIRST:  reg_hf   = i_cfg.data;
                    CFG_HEADER_SECOND: reg_hs   = i_cfg.data;
                    CFG_CHECK_FILL:    reg_fill = i_cfg.data;
                    CFG_FOOTER_FIRST:  reg_f0   = i_cfg.data;
                    CFG_FOOTER_SECOND: reg_f1   = i_cfg.data;
                    default: ;
                endcase
            end
            // result beats first: they can only stem from bytes of earlier edges
            if (i_res.valid && i_res.ready) begin
                got = '{i_res.src_device, i_res.dst_device, i_res.command, i_res.param_count,
                        i_res.has_param, i_res.param_index, i_res.param_byte, i_res.last};
                beat_count++;
                if (owed_beats.size() == 0) begin
                    $display("%0t: result beat with nothing expected, actual %h", $time, got);
                    fail_count++;
                end else begin
                    want = owed_beats.pop_front();
                    check_field("src_device",  want.src,       got.src);
                    check_field("dst_device",  want.dst,       got.dst);
                    check_field("command",     want.cmd,       got.cmd);
                    check_field("param_count", want.count,     got.count);
                    check_field("has_param",   want.has_param, got.has_param);
                    check_field("param_index", want.pidx,      got.pidx);
                    check_field("param_byte",  want.pbyte,     got.pbyte);
                    check_field("last",        want.last,      got.last);
                end
            end
            if (i_rx.valid && i_rx.ready) begin
                step_beats = 0;
                if (parse_byte(i_rx.rx_byte)) begin
                    // rejected frame: reparse the stored bytes after its header
                    reparse_count++;
                    run_len    = store_fill;
                    store_fill = 0;
                    pos        = 0;
                    while (pos < run_len && pos < STORE_DEPTH) begin
                        nb = store[pos];
                        pos++;
                        if (parse_byte(nb)) begin
                            reparse_count++;
                            inner = store_fill;
                            rest  = run_len - pos;
                            if (inner + rest > STORE_DEPTH || inner > pos) rest = 0;
                            for (int k = 0; k < rest; k++) store[inner + k] = store[pos + k];
                            run_len    = inner + rest;
                            store_fill = 0;
                            pos        = 0;
                        end
                    end
                end
            end
        end
    end

endmodule

@@ sim/command_frame_deframer_tb.sv @@
`timescale 1ns / 1ps
module command_frame_deframer_tb;
    import cfd_pkg::*;

    localparam int NUM_SETTINGS  = 6;
    localparam int PHASE_BYTES   = 26;
    localparam int SETTLE_CYCLES = 600;

    localparam logic [CFG_IDX_W-1:0] REG_ORDER [5] = '{
        CFG_HEADER_FIRST, CFG_HEADER_SECOND, CFG_CHECK_FILL,
        CFG_FOOTER_FIRST, CFG_FOOTER_SECOND
    };

    typedef struct {
        logic [BYTE_W-1:0] hf;
        logic [BYTE_W-1:0] hs;
        logic [BYTE_W-1:0] fill;
        logic [BYTE_W-1:0] f0;
        logic [BYTE_W-1:0] f1;
    } link_setting_t;

    typedef enum {
        FR_GOOD,
        FR_BAD_CHECK,
        FR_BAD_FOOTER,
        FR_LONG,
        FR_CUT,
        FR_NOISE
    } frame_kind_t;

    logic i_clk;
    logic i_rst_n;

    cfd_byte_if   rx_if ();
    cfd_result_if res_if ();
    cfd_cfg_if    cfg_if ();

    int fail_count;
    int pending;
    int beats;
    int reparsed;

    link_setting_t     cur;
    logic [BYTE_W-1:0] link_q [$];
    int                bytes_sent = 0;
    bit                tx_steady = 1'b0;
    bit                res_steady = 1'b0;

    command_frame_deframer u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    command_frame_deframer_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx         (rx_if),
        .i_res        (res_if),
        .i_cfg        (cfg_if),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_beats      (beats),
        .o_reparsed   (reparsed)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("Verification failed");
        $finish;
    end

    // result side back-pressure, one stall draw per beat
    initial begin
        int hold;
        hold = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                res_if.ready <= 1'b0;
            end else if (!res_if.ready) begin
                if (hold <= 1) res_if.ready <= 1'b1;
                else hold--;
            end else if (res_if.valid) begin
                hold = res_steady ? 0 : $urandom_range(0, 13);
                if (hold != 0) res_if.ready <= 1'b0;
            end
        end
    end

    task automatic load_setting(input link_setting_t s);
        logic [BYTE_W-1:0] vals [5];
        vals = '{s.hf, s.hs, s.fill, s.f0, s.f1};
        cfg_if.valid <= 1'b1;
        foreach (vals[i]) begin
            cfg_if.index <= REG_ORDER[i];
            cfg_if.data  <= vals[i];
            @(posedge i_clk);
            while (!cfg_if.ready) @(posedge i_clk);
        end
        cfg_if.valid <= 1'b0;
    endtask

    task automatic send_link_q();
        int gap;
        while (link_q.size() != 0) begin
            gap = tx_steady ? 0 : $urandom_range(0, 13);
            if (gap != 0) begin
                rx_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            rx_if.valid   <= 1'b1;
            rx_if.rx_byte <= link_q.pop_front();
            @(posedge i_clk);
            while (!rx_if.ready) @(posedge i_clk);
            bytes_sent++;
        end
    endtask

    task automatic wait_idle();
        rx_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic queue_frame(input frame_kind_t kind);
        int n;
        int len;
        int pick;
        int spoil;
        if (kind == FR_NOISE) begin
            n = $urandom_range(1, 8);
            repeat (n) begin
                case ($urandom_range(0, 3))
                    0:       link_q.push_back(cur.hf);
                    1:       link_q.push_back(cur.hs);
                    default: link_q.push_back(8'($urandom_range(0, 255)));
                endcase
            end
            return;
        end
        // truncated frame, then a full one that may get swallowed and reparsed
        if (kind == FR_CUT) begin
            link_q.push_back(cur.hf);
            link_q.push_back(cur.hs);
            n = $urandom_range(1, 5);
            repeat (n) link_q.push_back(8'($urandom_range(0, 255)));
        end
        pick = $urandom_range(0, 9);
        if (pick < 2) len = PARAM_MAX;
        else if (pick == 2) len = $urandom_range(5, PARAM_MAX - 1);
        else len = $urandom_range(0, 4);
        if (kind == FR_LONG) len = $urandom_range(PARAM_MAX + 1, 255);
        link_q.push_back(cur.hf);
        link_q.push_back(cur.hs);
        repeat (3) link_q.push_back(8'($urandom_range(0, 255)));
        link_q.push_back(8'(len));
        if (kind == FR_LONG) return;
        repeat (len) link_q.push_back(8'($urandom_range(0, 255)));
        spoil = $urandom_range(0, 1);
        link_q.push_back((kind == FR_BAD_CHECK && spoil == 0) ?
                         cur.fill ^ 8'($urandom_range(1, 255)) : cur.fill);
        link_q.push_back((kind == FR_BAD_CHECK && spoil == 1) ?
                         cur.fill ^ 8'($urandom_range(1, 255)) : cur.fill);
        link_q.push_back((kind == FR_BAD_FOOTER && spoil == 0) ?
                         cur.f0 ^ 8'($urandom_range(1, 255)) : cur.f0);
        link_q.push_back((kind == FR_BAD_FOOTER && spoil == 1) ?
                         cur.f1 ^ 8'($urandom_range(1, 255)) : cur.f1);
    endtask

    initial begin
        link_setting_t plan [NUM_SETTINGS];
        int            pick;
        int            phase_start;
        frame_kind_t   kind;
        rx_if.valid   <= 1'b0;
        rx_if.rx_byte <= '0;
        cfg_if.valid  <= 1'b0;
        cfg_if.index  <= CFG_HEADER_FIRST;
        cfg_if.data   <= '0;
        i_rst_n       <= 1'b0;
        plan[0] = '{8'hAA, 8'h55, 8'h00, 8'h0D, 8'h0A};
        plan[1] = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        plan[2] = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        plan[3] = '{8'h7E, 8'h7E, 8'h5A, 8'h7E, 8'h7E};
        for (int p = 4; p < NUM_SETTINGS; p++) begin
            plan[p] = '{8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255))};
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int p = 0; p < NUM_SETTINGS; p++) begin
            cur = plan[p];
            load_setting(cur);
            if (p == 0) begin
                // empty frame behind a repeated first header byte, extremes in the body
                link_q = '{8'hAA, 8'hAA, 8'h55, 8'h00, 8'hFF, 8'h5A, 8'h00,
                           8'h00, 8'h00, 8'h0D, 8'h0A};
                // length above the limit
                link_q = {link_q, 8'hAA, 8'h55, 8'h01, 8'h02, 8'h03, 8'h11};
                // bad second check byte
                link_q = {link_q, 8'hAA, 8'h55, 8'h81, 8'h42, 8'h24, 8'h01, 8'hFF,
                          8'h00, 8'h33, 8'h0D, 8'h0A};
                send_link_q();
            end
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES) begin
                if ($urandom_range(0, 7) == 0) tx_steady = !tx_steady;
                if ($urandom_range(0, 7) == 0) res_steady = !res_steady;
                pick = $urandom_range(0, 99);
                if (pick < 55) kind = FR_GOOD;
                else if (pick < 65) kind = FR_BAD_CHECK;
                else if (pick < 75) kind = FR_BAD_FOOTER;
                else if (pick < 82) kind = FR_LONG;
                else if (pick < 91) kind = FR_CUT;
                else kind = FR_NOISE;
                queue_frame(kind);
                send_link_q();
                if ($urandom_range(0, 19) == 0) wait_idle();
            end
            wait_idle();
        end

        $display("Summary: %0d link bytes under %0d register settings, %0d result beats checked",
                 bytes_sent, NUM_SETTINGS, beats);
        $display("Summary: %0d rejected frames reparsed from the frame store", reparsed);
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
